@@ src/mpd_pkg.sv @@
package mpd_pkg;

    // Field widths
    localparam int unsigned DUR_W      = 20;
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned PAT_W      = 5;
    localparam int unsigned CNT_W      = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned S_TDATA_W  = 24;
    localparam int unsigned M_TDATA_W  = 8;
    localparam int unsigned STEP_W     = 4;

    // Default sizes
    localparam int unsigned DEF_MESSAGE_DEPTH = 32;
    localparam int unsigned DEF_MAX_SYMBOLS   = 5;

    // Register reset values
    localparam logic [DUR_W-1:0] DOT_LIMIT_RST  = 20'd300;
    localparam logic [DUR_W-1:0] DASH_LIMIT_RST = 20'd900;
    localparam logic [DUR_W-1:0] LETTER_GAP_RST = 20'd900;
    localparam logic [DUR_W-1:0] WORD_GAP_RST   = 20'd3000;
    localparam logic [DUR_W-1:0] END_GAP_RST    = 20'd7000;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DOT_LIMIT,
        REG_DASH_LIMIT,
        REG_LETTER_GAP,
        REG_WORD_GAP,
        REG_END_GAP
    } cfg_reg_t;

    // Event class of the held input item
    typedef enum logic [2:0] {
        EV_NONE,
        EV_DOT,
        EV_DASH,
        EV_LETTER,
        EV_WORD,
        EV_END
    } event_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_CLASSIFY,
        OP_ADD_SYM,
        OP_END_LETTER,
        OP_STORE_SPACE,
        OP_FLUSH_START,
        OP_FLUSH_OUT,
        OP_CLEAR
    } uop_t;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_EV_NONE,
        C_EV_PULSE,
        C_EV_LETTER,
        C_EV_WORD,
        C_STORE_EMPTY,
        C_FLUSH_MORE
    } ucond_t;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        uop_t   op;
        ucond_t cond;
        step_t  target;
    } uword_t;

    // Program addresses
    localparam step_t STEP_WAIT        = 4'd0;
    localparam step_t STEP_CLASSIFY    = 4'd1;
    localparam step_t STEP_CHK_NONE    = 4'd2;
    localparam step_t STEP_CHK_PULSE   = 4'd3;
    localparam step_t STEP_END_LETTER  = 4'd4;
    localparam step_t STEP_CHK_WORD    = 4'd5;
    localparam step_t STEP_FLUSH_START = 4'd6;
    localparam step_t STEP_FLUSH_OUT   = 4'd7;
    localparam step_t STEP_CLEAR       = 4'd8;
    localparam step_t STEP_SPACE       = 4'd9;
    localparam step_t STEP_ADD_SYM     = 4'd10;

    // Control store: a jump is taken when its condition holds, else fall through
    function automatic uword_t ucode_rom(input step_t step);
        uword_t w;
        begin
            unique case (step)
                STEP_WAIT:        w = '{OP_ACCEPT,      C_NO_INPUT,    STEP_WAIT};
                STEP_CLASSIFY:    w = '{OP_CLASSIFY,    C_NEVER,       STEP_WAIT};
                STEP_CHK_NONE:    w = '{OP_NOP,         C_EV_NONE,     STEP_WAIT};
                STEP_CHK_PULSE:   w = '{OP_NOP,         C_EV_PULSE,    STEP_ADD_SYM};
                STEP_END_LETTER:  w = '{OP_END_LETTER,  C_EV_LETTER,   STEP_WAIT};
                STEP_CHK_WORD:    w = '{OP_NOP,         C_EV_WORD,     STEP_SPACE};
                STEP_FLUSH_START: w = '{OP_FLUSH_START, C_STORE_EMPTY, STEP_CLEAR};
                STEP_FLUSH_OUT:   w = '{OP_FLUSH_OUT,   C_FLUSH_MORE,  STEP_FLUSH_OUT};
                STEP_CLEAR:       w = '{OP_CLEAR,       C_ALWAYS,      STEP_WAIT};
                STEP_SPACE:       w = '{OP_STORE_SPACE, C_ALWAYS,      STEP_WAIT};
                STEP_ADD_SYM:     w = '{OP_ADD_SYM,     C_ALWAYS,      STEP_WAIT};
                default:          w = '{OP_NOP,         C_ALWAYS,      STEP_WAIT};
            endcase
            return w;
        end
    endfunction

    // Morse ROM; pattern has dash = 1, newest symbol in bit 0
    function automatic logic [CHAR_W-1:0] morse_rom(input logic [CNT_W-1:0] cnt,
                                                    input logic [PAT_W-1:0] pat);
        logic [CHAR_W-1:0] c;
        begin
            c = CHAR_NONE;
            case (cnt)
                3'd1: c = pat[0] ? 7'h54 : 7'h45;              // T E
                3'd2:
                    case (pat[1:0])
                        2'd0:    c = 7'h49;                    // I
                        2'd1:    c = 7'h41;                    // A
                        2'd2:    c = 7'h4E;                    // N
                        default: c = 7'h4D;                    // M
                    endcase
                3'd3:
                    case (pat[2:0])
                        3'd0:    c = 7'h53;                    // S
                        3'd1:    c = 7'h55;                    // U
                        3'd2:    c = 7'h52;                    // R
                        3'd3:    c = 7'h57;                    // W
                        3'd4:    c = 7'h44;                    // D
                        3'd5:    c = 7'h4B;                    // K
                        3'd6:    c = 7'h47;                    // G
                        default: c = 7'h4F;                    // O
                    endcase
                3'd4:
                    case (pat[3:0])
                        4'd0:    c = 7'h48;                    // H
                        4'd1:    c = 7'h56;                    // V
                        4'd2:    c = 7'h46;                    // F
                        4'd4:    c = 7'h4C;                    // L
                        4'd6:    c = 7'h50;                    // P
                        4'd7:    c = 7'h4A;                    // J
                        4'd8:    c = 7'h42;                    // B
                        4'd9:    c = 7'h58;                    // X
                        4'd10:   c = 7'h43;                    // C
                        4'd11:   c = 7'h59;                    // Y
                        4'd12:   c = 7'h5A;                    // Z
                        4'd13:   c = 7'h51;                    // Q
                        default: c = CHAR_NONE;
                    endcase
                3'd5:
                    case (pat)
                        5'h1F:   c = 7'h30;
                        5'h0F:   c = 7'h31;
                        5'h07:   c = 7'h32;
                        5'h03:   c = 7'h33;
                        5'h01:   c = 7'h34;
                        5'h00:   c = 7'h35;
                        5'h10:   c = 7'h36;
                        5'h18:   c = 7'h37;
                        5'h1C:   c = 7'h38;
                        5'h1E:   c = 7'h39;
                        default: c = CHAR_NONE;
                    endcase
                default: c = CHAR_NONE;
            endcase
            return c;
        end
    endfunction

endpackage

@@ src/morse_pulse_decoder.sv @@
// Morse pulse decoder. Each input transfer is one measured line event:
// s_tuser = 1 for a high pulse, 0 for a low gap, with its length in ms in
// s_tdata. Pulses build the dot/dash group of the current letter; gaps end
// the letter, decode it and append it (and, for a word gap, a space) to a
// message store of MESSAGE_DEPTH characters. An end gap streams the stored
// message out on m_*, one character per transfer, with tlast on the final one
// and tuser set if characters were dropped because the store was full; the
// store is then cleared. Control is a microcoded sequencer that walks a small
// control store, one step per cycle, and takes one event at a time. While
// the sink is ready, a flush sends one character per cycle from the store's
// read port.
// Configuration writes are taken at any time but are meant for idle periods.
module morse_pulse_decoder #(
    parameter int unsigned MESSAGE_DEPTH = mpd_pkg::DEF_MESSAGE_DEPTH,
    parameter int unsigned MAX_SYMBOLS   = mpd_pkg::DEF_MAX_SYMBOLS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // event in
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mpd_pkg::S_TDATA_W-1:0]      s_tdata,   // [19:0] duration_ms
    input  logic                               s_tuser,   // [0] func
    // characters out
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mpd_pkg::M_TDATA_W-1:0]      m_tdata,   // [6:0] char_code
    output logic                               m_tlast,
    output logic                               m_tuser,   // [0] overflowed
    // register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mpd_pkg::DUR_W-1:0]          cfg_data
);

    import mpd_pkg::*;

    localparam int unsigned AW = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;
    localparam int unsigned LW = $clog2(MESSAGE_DEPTH + 1);

    // Configuration registers
    logic [DUR_W-1:0] dot_limit_reg,  dot_limit_next;
    logic [DUR_W-1:0] dash_limit_reg, dash_limit_next;
    logic [DUR_W-1:0] letter_gap_reg, letter_gap_next;
    logic [DUR_W-1:0] word_gap_reg,   word_gap_next;
    logic [DUR_W-1:0] end_gap_reg,    end_gap_next;

    // Sequencer and datapath state
    step_t            step_reg,  step_next;
    logic             func_reg,  func_next;
    logic [DUR_W-1:0] dur_reg,   dur_next;
    event_t           ev_reg,    ev_next;
    logic [PAT_W-1:0] pat_reg,   pat_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             long_reg,  long_next;
    logic [LW-1:0]    len_reg,   len_next;
    logic             ovf_reg,   ovf_next;
    logic [LW-1:0]    idx_reg,   idx_next;

    // Output register
    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] m_char_reg,  m_char_next;
    logic              m_last_reg,  m_last_next;
    logic              m_ovf_reg,   m_ovf_next;

    uword_t            uw;
    event_t            ev_comb;
    logic              cond_true;
    logic              out_free;
    logic              load_out;
    logic              last_now;
    logic [LW-1:0]     idx_plus1;
    logic              store_req;
    logic [CHAR_W-1:0] store_char;
    logic [CHAR_W-1:0] group_char;
    logic              group_full;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    mpd_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MESSAGE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (store_char),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign uw        = ucode_rom(step_reg);
    assign s_tready  = (uw.op == OP_ACCEPT);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign idx_plus1 = idx_reg + LW'(1);
    assign last_now  = (idx_plus1 == len_reg);
    assign load_out  = (uw.op == OP_FLUSH_OUT) && out_free;
    assign group_full = (cnt_reg >= CNT_W'(MAX_SYMBOLS));

    // Decoded character of the current group
    always_comb
    begin
        if (long_reg || (cnt_reg > CNT_W'(MAX_SYMBOLS)))
            group_char = CHAR_NONE;
        else
            group_char = morse_rom(cnt_reg, pat_reg);
    end

    // Event classification against the limits
    always_comb
    begin
        ev_comb = EV_NONE;
        if (func_reg)
        begin
            if (dur_reg < dot_limit_reg)
                ev_comb = EV_DOT;
            else if ((dur_reg > dot_limit_reg) && (dur_reg < dash_limit_reg))
                ev_comb = EV_DASH;
        end
        else
        begin
            if (dur_reg > end_gap_reg)
                ev_comb = EV_END;
            else if (dur_reg > word_gap_reg)
                ev_comb = EV_WORD;
            else if ((dur_reg > letter_gap_reg) && (dur_reg < word_gap_reg))
                ev_comb = EV_LETTER;
        end
    end

    // Jump condition
    always_comb
    begin
        unique case (uw.cond)
            C_NEVER:       cond_true = 1'b0;
            C_ALWAYS:      cond_true = 1'b1;
            C_NO_INPUT:    cond_true = !s_tvalid;
            C_EV_NONE:     cond_true = (ev_reg == EV_NONE);
            C_EV_PULSE:    cond_true = (ev_reg == EV_DOT) || (ev_reg == EV_DASH);
            C_EV_LETTER:   cond_true = (ev_reg == EV_LETTER);
            C_EV_WORD:     cond_true = (ev_reg == EV_WORD);
            C_STORE_EMPTY: cond_true = (len_reg == '0);
            C_FLUSH_MORE:  cond_true = !out_free || !last_now;
            default:       cond_true = 1'b1;
        endcase
    end

    assign step_next = cond_true ? uw.target : step_t'(step_reg + 1'b1);

    // Datapath operations
    always_comb
    begin
        func_next  = func_reg;
        dur_next   = dur_reg;
        ev_next    = ev_reg;
        pat_next   = pat_reg;
        cnt_next   = cnt_reg;
        long_next  = long_reg;
        idx_next   = idx_reg;
        store_req  = 1'b0;
        store_char = group_char;
        ram_re     = 1'b0;
        ram_raddr  = idx_plus1[AW-1:0];

        unique case (uw.op)
            OP_ACCEPT:
            begin
                if (s_tvalid)
                begin
                    func_next = s_tuser;
                    dur_next  = s_tdata[DUR_W-1:0];
                end
            end
            OP_CLASSIFY:
            begin
                ev_next = ev_comb;
            end
            OP_ADD_SYM:
            begin
                if (group_full)
                begin
                    long_next = 1'b1;
                end
                else
                begin
                    pat_next = {pat_reg[PAT_W-2:0], (ev_reg == EV_DASH)};
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            OP_END_LETTER:
            begin
                store_req = (cnt_reg != '0) || long_reg;
                pat_next  = '0;
                cnt_next  = '0;
                long_next = 1'b0;
            end
            OP_STORE_SPACE:
            begin
                store_req  = 1'b1;
                store_char = CHAR_SPACE;
            end
            OP_FLUSH_START:
            begin
                idx_next  = '0;
                ram_re    = 1'b1;
                ram_raddr = '0;
            end
            OP_FLUSH_OUT:
            begin
                if (out_free)
                begin
                    idx_next = idx_plus1;
                    ram_re   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Message store append and clear
    always_comb
    begin
        len_next  = len_reg;
        ovf_next  = ovf_reg;
        ram_we    = 1'b0;
        ram_waddr = len_reg[AW-1:0];
        if (store_req)
        begin
            if (len_reg < LW'(MESSAGE_DEPTH))
            begin
                ram_we   = 1'b1;
                len_next = len_reg + LW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (uw.op == OP_CLEAR)
        begin
            len_next = '0;
            ovf_next = 1'b0;
        end
    end

    // Output register
    always_comb
    begin
        m_valid_next = m_valid_reg && !m_tready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        m_ovf_next   = m_ovf_reg;
        if (load_out)
        begin
            m_valid_next = 1'b1;
            m_char_next  = ram_rdata;
            m_last_next  = last_now;
            m_ovf_next   = ovf_reg;
        end
    end

    // Register writes
    always_comb
    begin
        dot_limit_next  = dot_limit_reg;
        dash_limit_next = dash_limit_reg;
        letter_gap_next = letter_gap_reg;
        word_gap_next   = word_gap_reg;
        end_gap_next    = end_gap_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_DOT_LIMIT:  dot_limit_next  = cfg_data;
                REG_DASH_LIMIT: dash_limit_next = cfg_data;
                REG_LETTER_GAP: letter_gap_next = cfg_data;
                REG_WORD_GAP:   word_gap_next   = cfg_data;
                REG_END_GAP:    end_gap_next    = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_limit_reg  <= DOT_LIMIT_RST;
            dash_limit_reg <= DASH_LIMIT_RST;
            letter_gap_reg <= LETTER_GAP_RST;
            word_gap_reg   <= WORD_GAP_RST;
            end_gap_reg    <= END_GAP_RST;
            step_reg       <= STEP_WAIT;
            ev_reg         <= EV_NONE;
            pat_reg        <= '0;
            cnt_reg        <= '0;
            long_reg       <= 1'b0;
            len_reg        <= '0;
            ovf_reg        <= 1'b0;
            idx_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            dot_limit_reg  <= dot_limit_next;
            dash_limit_reg <= dash_limit_next;
            letter_gap_reg <= letter_gap_next;
            word_gap_reg   <= word_gap_next;
            end_gap_reg    <= end_gap_next;
            step_reg       <= step_next;
            ev_reg         <= ev_next;
            pat_reg        <= pat_next;
            cnt_reg        <= cnt_next;
            long_reg       <= long_next;
            len_reg        <= len_next;
            ovf_reg        <= ovf_next;
            idx_reg        <= idx_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        dur_reg    <= dur_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
        m_ovf_reg  <= m_ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - CHAR_W){1'b0}}, m_char_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_ovf_reg;

    // Store never holds more than its depth
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(MESSAGE_DEPTH))
        else $error("message length beyond store depth");

    // Overflow only raised while the store is full
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovf_reg) |-> $past(len_reg) == LW'(MESSAGE_DEPTH))
        else $error("overflow raised with room left");

    // Loading the final character leads straight to the clearing step
    a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && last_now) |=> (step_reg == STEP_CLEAR))
        else $error("flush did not end in clear");

endmodule

@@ src/mpd_ram.sv @@
module mpd_ram #(
    parameter int unsigned WIDTH = 7,
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
